// ===== hw/rtl/stuffed_info_frame_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stuffed info frame encoder
// Clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STUFFED_INFO_FRAME_ENCODER_ASSERT_SVH
`define STUFFED_INFO_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define SIF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SIF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sif_pkg.sv =====
// ----------------------------------------------------------------------------
// sif_pkg
// Types, register indexes and helpers shared by the framer modules.
// ----------------------------------------------------------------------------
package sif_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CTRL_SEQ_ONE  = 8'h40;
	localparam logic [7:0] CTRL_SEQ_ZERO = 8'h00;

	localparam logic [7:0] FLAG_RESET    = 8'h7E;
	localparam logic [7:0] ESCAPE_RESET  = 8'h7D;
	localparam logic [7:0] ESC_XOR_RESET = 8'h20;
	localparam logic [7:0] ADDRESS_RESET = 8'h03;

	typedef enum logic [1:0] {
		REG_FLAG    = 2'd0,
		REG_ESCAPE  = 2'd1,
		REG_ESC_XOR = 2'd2,
		REG_ADDRESS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] escape_xor;
		logic [7:0] address_byte;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_frame;
		logic       last_of_frame;
		logic       empty_frame;
		logic       seq_bit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	// classified work for the back end
	typedef struct packed {
		logic       hdr;
		logic       seq_bit;
		logic       has_data;
		logic [7:0] data_byte;
		logic       trl;
		logic [7:0] chk_byte;
	} job_t;

	typedef enum logic [3:0] {
		ST_HFLAG  = 4'd0,
		ST_HADDR  = 4'd1,
		ST_HCTRL  = 4'd2,
		ST_HXOR   = 4'd3,
		ST_DATA   = 4'd4,
		ST_DATA2  = 4'd5,
		ST_CHK    = 4'd6,
		ST_CHK2   = 4'd7,
		ST_FLAG   = 4'd8
	} step_t;

	function automatic logic needs_stuff(input logic [7:0] b, input cfg_t c);
		return (b == c.flag_byte) || (b == c.escape_byte);
	endfunction

	function automatic logic [7:0] ctrl_of(input logic seq);
		return seq ? CTRL_SEQ_ONE : CTRL_SEQ_ZERO;
	endfunction

endpackage

// ===== hw/rtl/sif_front.sv =====
// ----------------------------------------------------------------------------
// sif_front
// Accepts input words, keeps the running check byte, classifies each word.
// ----------------------------------------------------------------------------
module sif_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sif_pkg::in_item_t in_data,
	input  logic             q_full,
	output logic             q_push,
	output sif_pkg::job_t    q_job
);
	import sif_pkg::*;

	logic [7:0] acc_q;
	logic [7:0] chk;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		if (in_data.empty_frame) begin
			chk = '0;
		end else if (in_data.first_of_frame) begin
			chk = in_data.data_byte;
		end else begin
			chk = acc_q ^ in_data.data_byte;
		end
	end

	always_comb begin
		q_job.hdr       = in_data.empty_frame || in_data.first_of_frame;
		q_job.seq_bit   = in_data.seq_bit;
		q_job.has_data  = !in_data.empty_frame;
		q_job.data_byte = in_data.data_byte;
		q_job.trl       = in_data.empty_frame || in_data.last_of_frame;
		q_job.chk_byte  = chk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (q_push) begin
			acc_q <= q_job.trl ? 8'h00 : chk;
		end
	end

endmodule

// ===== hw/rtl/sif_fifo.sv =====
// ----------------------------------------------------------------------------
// sif_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module sif_fifo #(
	parameter int unsigned Depth = sif_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sif_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output sif_pkg::job_t head
);
	import sif_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == FullCnt);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sif_back.sv =====
// ----------------------------------------------------------------------------
// sif_back
// Sequences one queued job into its header, stuffed data byte, check byte and flag, as the job calls for.
// ----------------------------------------------------------------------------
`include "stuffed_info_frame_encoder_assert.svh"

module sif_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sif_pkg::cfg_t      cfg,
	input  logic               job_valid,
	input  sif_pkg::job_t      job,
	output logic               job_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output sif_pkg::out_item_t out_data
);
	import sif_pkg::*;

	logic      busy_q;
	step_t     step_q;
	step_t     cur_step;
	step_t     nxt_step;
	logic      done;
	logic      fire;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t item;

	assign fire    = job_valid && (!out_valid_q || out_ready);
	assign job_pop = fire && done;

	// next step
	always_comb begin
		if (busy_q) begin
			cur_step = step_q;
		end else if (job.hdr) begin
			cur_step = ST_HFLAG;
		end else if (job.has_data) begin
			cur_step = ST_DATA;
		end else begin
			cur_step = ST_CHK;
		end
		done     = 1'b0;
		nxt_step = cur_step;
		case (cur_step)
			ST_HFLAG: nxt_step = ST_HADDR;
			ST_HADDR: nxt_step = ST_HCTRL;
			ST_HCTRL: nxt_step = ST_HXOR;
			ST_HXOR:  nxt_step = job.has_data ? ST_DATA : ST_CHK;
			ST_DATA: begin
				if (needs_stuff(job.data_byte, cfg)) begin
					nxt_step = ST_DATA2;
				end else if (job.trl) begin
					nxt_step = ST_CHK;
				end else begin
					done = 1'b1;
				end
			end
			ST_DATA2: begin
				if (job.trl) begin
					nxt_step = ST_CHK;
				end else begin
					done = 1'b1;
				end
			end
			ST_CHK:   nxt_step = needs_stuff(job.chk_byte, cfg) ? ST_CHK2 : ST_FLAG;
			ST_CHK2:  nxt_step = ST_FLAG;
			ST_FLAG:  done = 1'b1;
			default:  done = 1'b1;
		endcase
	end

	// output word
	always_comb begin
		item.run_last  = done;
		item.frame_end = (cur_step == ST_FLAG);
		case (cur_step)
			ST_HFLAG: item.out_byte = cfg.flag_byte;
			ST_HADDR: item.out_byte = cfg.address_byte;
			ST_HCTRL: item.out_byte = ctrl_of(job.seq_bit);
			ST_HXOR:  item.out_byte = cfg.address_byte ^ ctrl_of(job.seq_bit);
			ST_DATA:  item.out_byte = needs_stuff(job.data_byte, cfg) ?
				cfg.escape_byte : job.data_byte;
			ST_DATA2: item.out_byte = job.data_byte ^ cfg.escape_xor;
			ST_CHK:   item.out_byte = needs_stuff(job.chk_byte, cfg) ?
				cfg.escape_byte : job.chk_byte;
			ST_CHK2:  item.out_byte = job.chk_byte ^ cfg.escape_xor;
			ST_FLAG:  item.out_byte = cfg.flag_byte;
			default:  item.out_byte = cfg.flag_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_HFLAG;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q      <= !done;
				step_q      <= nxt_step;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SIF_ASSERT_NOW(a_flag_ends_run, out_valid_q && out_q.frame_end, out_q.run_last, "closing flag not last word of its run")
	`SIF_ASSERT_NOW(a_busy_has_job, busy_q, job_valid, "mid-job without a queued job")
	`SIF_ASSERT_NEXT(a_fire_loads, fire, out_valid_q, "output register not loaded")

endmodule

// ===== hw/rtl/stuffed_info_frame_encoder.sv =====
// An accepted input word is written into the job queue; its output words then pass
// through the back end's output register. Throughput: one output word per cycle while
// out_ready allows; a word causes 1 to 9 outputs, a plain payload one, a stuffed one two.
// The job queue (QueueDepth entries) lets the input side run ahead of output stalls.
// Reset: configuration returns to its defaults, queue empties, check byte clears.
// ----------------------------------------------------------------------------
// stuffed_info_frame_encoder
// Byte-stuffing information frame encoder with XOR check byte.
// ----------------------------------------------------------------------------
module stuffed_info_frame_encoder #(
	parameter int unsigned QueueDepth = sif_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sif_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sif_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  sif_pkg::reg_idx_t   cfg_index,
	input  logic [7:0]          cfg_data
);
	import sif_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic full;
	logic not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte    <= FLAG_RESET;
			cfg_q.escape_byte  <= ESCAPE_RESET;
			cfg_q.escape_xor   <= ESC_XOR_RESET;
			cfg_q.address_byte <= ADDRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FLAG:    cfg_q.flag_byte    <= cfg_data;
				REG_ESCAPE:  cfg_q.escape_byte  <= cfg_data;
				REG_ESC_XOR: cfg_q.escape_xor   <= cfg_data;
				REG_ADDRESS: cfg_q.address_byte <= cfg_data;
				default:     cfg_q              <= cfg_q;
			endcase
		end
	end

	sif_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (full),
		.q_push   (push),
		.q_job    (push_job)
	);

	sif_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head_job)
	);

	sif_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (not_empty),
		.job       (head_job),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
